// ===== sv/segment_sort_equal_digest_grouper_top_defines.svh =====
// Assertion macros shared by the grouper checker.
// No dependencies.
`ifndef SEGMENT_SORT_EQUAL_DIGEST_GROUPER_TOP_DEFINES_SVH
`define SEGMENT_SORT_EQUAL_DIGEST_GROUPER_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SSG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define SSG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== sv/ssg_pkg.sv =====
// Types and constants for the segment sorter and grouper.
// No dependencies.
package ssg_pkg;
    localparam int DIGEST_W  = 256;
    localparam int DBYTES_W  = 6;
    localparam int OFFSET_W  = 6;
    localparam int SIZE_W    = 7;
    localparam int BASE_W    = 32;
    localparam int FSIZE_W   = 48;
    localparam int GNUM_W    = 32;
    localparam logic [DBYTES_W-1:0] DBYTES_RESET = 6'd32;
    localparam logic [DBYTES_W-1:0] DBYTES_MAX   = 6'd32;
    localparam logic [SIZE_W-1:0]   GROUP_MIN    = 7'd2;

    typedef struct packed {
        logic [63:0]        digest_word0;
        logic [63:0]        digest_word1;
        logic [63:0]        digest_word2;
        logic [63:0]        digest_word3;
        logic [BASE_W-1:0]  segment_base;
        logic [FSIZE_W-1:0] size_of_file;
        logic               last_in_segment;
        logic               final_segment;
    } req_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] source_offset;
        logic                in_group;
        logic [BASE_W-1:0]   group_start;
        logic [SIZE_W-1:0]   group_size;
        logic [FSIZE_W-1:0]  group_file_size;
        logic [GNUM_W-1:0]   group_number;
        logic                run_first;
        logic                last_result;
    } res_t;

    // control from the top level to each cell
    typedef struct packed {
        logic ins;    // insert a new entry
        logic shift;  // drain: move entries towards cell 0
        logic clear;  // start of a new segment
    } cell_ctl_t;
endpackage

// ===== sv/ssg_cell.sv =====
// One cell of the sorting chain: holds one entry and its key.
// Depends on ssg_pkg.
module ssg_cell #(
    parameter int DIGEST_BITS = 256,
    parameter int OFF_W = 6
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ssg_pkg::cell_ctl_t     ctl,
    input  logic [DIGEST_BITS-1:0] new_key,
    input  logic [OFF_W-1:0]       new_off,
    input  logic [DIGEST_BITS-1:0] mask,
    input  logic                   prev_valid,
    input  logic                   prev_gt,
    input  logic [DIGEST_BITS-1:0] prev_key,
    input  logic [OFF_W-1:0]       prev_off,
    input  logic                   nxt_valid,
    input  logic [DIGEST_BITS-1:0] nxt_key,
    input  logic [OFF_W-1:0]       nxt_off,
    output logic                   valid,
    output logic                   gt,
    output logic [DIGEST_BITS-1:0] key,
    output logic [OFF_W-1:0]       off
);
    logic                   valid_reg, valid_next;
    logic [DIGEST_BITS-1:0] key_reg, key_next;
    logic [OFF_W-1:0]       off_reg, off_next;

    // strictly greater keeps insertion stable
    assign gt = valid_reg && ((key_reg & mask) > (new_key & mask));

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        off_next   = off_reg;
        if (ctl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.ins)
        begin
            if (gt)
            begin
                if (prev_gt)
                begin
                    key_next = prev_key;
                    off_next = prev_off;
                end
                else
                begin
                    key_next = new_key;
                    off_next = new_off;
                end
                valid_next = 1'b1;
            end
            else if (!valid_reg && prev_valid && !prev_gt)
            begin
                key_next   = new_key;
                off_next   = new_off;
                valid_next = 1'b1;
            end
            else if (!valid_reg && prev_valid && prev_gt)
            begin
                key_next   = prev_key;
                off_next   = prev_off;
                valid_next = 1'b1;
            end
        end
        else if (ctl.shift)
        begin
            valid_next = nxt_valid;
            key_next   = nxt_key;
            off_next   = nxt_off;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        off_reg <= off_next;
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign off   = off_reg;
endmodule

// ===== sv/ssg_group.sv =====
// Run scanner: follows the drained sorted stream and forms group fields.
// Depends on ssg_pkg.
module ssg_group #(
    parameter int DIGEST_BITS = 256,
    parameter int SEGMENT_DEPTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start_seg,
    input  logic [ssg_pkg::SIZE_W-1:0]      seg_len,
    input  logic                            emit,
    input  logic [DIGEST_BITS-1:0]          mask,
    input  logic                            fin,
    input  logic [SEGMENT_DEPTH*DIGEST_BITS-1:0] keys,
    input  logic [ssg_pkg::OFFSET_W-1:0]    head_off,
    input  logic [ssg_pkg::BASE_W-1:0]      base,
    input  logic [ssg_pkg::FSIZE_W-1:0]     fsize,
    output ssg_pkg::res_t                   res,
    output logic                            done
);
    localparam int SW = ssg_pkg::SIZE_W;
    logic [SW-1:0]  pos_reg, pos_next;      // sorted position of head
    logic [SW-1:0]  left_reg, left_next;    // entries left in current run
    logic [SW-1:0]  rsize_reg, rsize_next;
    logic [SW-1:0]  rstart_reg, rstart_next;
    logic [ssg_pkg::GNUM_W-1:0] gcnt_reg, gcnt_next, gnum_reg, gnum_next;
    logic [SW-1:0]  run_len;
    logic [SEGMENT_DEPTH-1:0] eq;

    // equality of each queued key with the head, for the run length
    always_comb
    begin
        for (int i = 0; i < SEGMENT_DEPTH; i++)
        begin
            eq[i] = ((keys[i*DIGEST_BITS +: DIGEST_BITS] & mask) ==
                     (keys[0 +: DIGEST_BITS] & mask));
        end
    end

    // run length is the position of the first entry that is unequal or past the segment
    always_comb
    begin
        logic [SW-1:0] rem;
        rem = seg_len - pos_reg;
        run_len = SW'(SEGMENT_DEPTH);
        for (int i = SEGMENT_DEPTH - 1; i >= 0; i--)
        begin
            if (!((SW'(i) < rem) && eq[i]))
            begin
                run_len = SW'(i);
            end
        end
    end

    always_comb
    begin
        logic first;
        logic [SW-1:0] sz;
        first = (left_reg == '0);
        sz = first ? run_len : rsize_reg;
        pos_next = pos_reg;
        left_next = left_reg;
        rsize_next = rsize_reg;
        rstart_next = rstart_reg;
        gcnt_next = gcnt_reg;
        gnum_next = gnum_reg;
        res.source_offset = head_off;
        res.in_group = (sz >= ssg_pkg::GROUP_MIN);
        res.group_start = base + ssg_pkg::BASE_W'(first ? pos_reg : rstart_reg);
        res.group_size = sz;
        res.group_file_size = fsize;
        res.group_number = !res.in_group ? '0 : (first ? gcnt_reg : gnum_reg);
        res.run_first = first;
        res.last_result = (pos_reg == seg_len - 1'b1);
        done = emit && res.last_result;
        if (start_seg)
        begin
            pos_next = '0;
            left_next = '0;
        end
        else if (emit)
        begin
            pos_next = pos_reg + 1'b1;
            if (!first)
            begin
                left_next = left_reg - 1'b1;
            end
            else
            begin
                left_next = run_len - 1'b1;
                rsize_next = run_len;
                rstart_next = pos_reg;
                gnum_next = gcnt_reg;
                if (res.in_group && gcnt_reg != '1)
                begin
                    gcnt_next = gcnt_reg + 1'b1;
                end
            end
            if (res.last_result && fin)
            begin
                gcnt_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            left_reg <= '0;
            gcnt_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            left_reg <= left_next;
            gcnt_reg <= gcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsize_reg <= rsize_next;
        rstart_reg <= rstart_next;
        gnum_reg <= gnum_next;
    end
endmodule

// ===== sv/segment_sort_equal_digest_grouper_top.sv =====
// Top level of the segment sorter and grouper: chain of insertion cells.
// Depends on ssg_pkg, ssg_cell and ssg_group.
//
//  channel   | ports                         | handshake
//  ----------+-------------------------------+---------------------
//  request   | start, busy, req              | start && !busy
//  result    | res_valid, res                | one cycle, no stall
//  config    | cfg_we, cfg_wdata             | cfg_we
//
// Each request is inserted into the registered sorted cell chain; the
// set of cells compares all held keys against it in parallel. On the last
// request of a segment busy rises and the chain drains one result per
// cycle from cell 0.
// Reset clears valid bits and counters; result strobes cannot be stalled.
module segment_sort_equal_digest_grouper_top #(
    parameter int SEGMENT_DEPTH = 64,
    parameter int DIGEST_BITS = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  ssg_pkg::req_t                  req,
    output logic                           res_valid,
    output ssg_pkg::res_t                  res,
    input  logic                           cfg_we,
    input  logic [ssg_pkg::DBYTES_W-1:0]   cfg_wdata
);
    localparam int OW = ssg_pkg::OFFSET_W;
    localparam int SW = ssg_pkg::SIZE_W;
    localparam int DB = (DIGEST_BITS / 8 > 32) ? 32 : DIGEST_BITS / 8;

    logic [ssg_pkg::DBYTES_W-1:0] dbytes_reg;
    logic [SW-1:0]  fill_reg, fill_next;
    logic           drain_reg, drain_next;
    logic           fin_reg, fin_next;
    logic [ssg_pkg::BASE_W-1:0]  base_reg, base_next;
    logic [ssg_pkg::FSIZE_W-1:0] fsize_reg, fsize_next;
    logic [DIGEST_BITS-1:0] new_key, mask;
    logic [255:0] full_key;
    logic accept, closing, done;
    ssg_pkg::cell_ctl_t ctl;
    ssg_pkg::res_t gres;
    logic [SEGMENT_DEPTH-1:0] v, g;
    logic [SEGMENT_DEPTH*DIGEST_BITS-1:0] keys;
    logic [SEGMENT_DEPTH*OW-1:0] offs;

    assign full_key = {req.digest_word0, req.digest_word1,
                       req.digest_word2, req.digest_word3};
    assign new_key = full_key[255 -: DIGEST_BITS];

    // compare mask: leading bytes only
    always_comb
    begin
        logic [5:0] n;
        n = (dbytes_reg > ssg_pkg::DBYTES_MAX) ? ssg_pkg::DBYTES_MAX : dbytes_reg;
        if (n > 6'(DB))
        begin
            n = 6'(DB);
        end
        for (int b = 0; b < DIGEST_BITS; b++)
        begin
            mask[DIGEST_BITS-1-b] = ((b / 8) < int'(n));
        end
    end

    assign busy = drain_reg;
    assign accept = start && !drain_reg;
    assign closing = accept && (req.last_in_segment || fill_reg == SW'(SEGMENT_DEPTH - 1));
    assign ctl.ins = accept;
    assign ctl.shift = drain_reg;
    assign ctl.clear = 1'b0;

    for (genvar i = 0; i < SEGMENT_DEPTH; i++)
    begin : g_cell
        logic pv, pg;
        logic [DIGEST_BITS-1:0] pk, nk;
        logic [OW-1:0] po, no;
        logic nv;
        if (i == 0)
        begin : g_first
            assign pv = 1'b1;
            assign pg = 1'b0;
            assign pk = new_key;
            assign po = fill_reg[OW-1:0];
        end
        else
        begin : g_rest
            assign pv = v[i-1];
            assign pg = g[i-1];
            assign pk = keys[(i-1)*DIGEST_BITS +: DIGEST_BITS];
            assign po = offs[(i-1)*OW +: OW];
        end
        if (i == SEGMENT_DEPTH - 1)
        begin : g_end
            assign nv = 1'b0;
            assign nk = '0;
            assign no = '0;
        end
        else
        begin : g_mid
            assign nv = v[i+1];
            assign nk = keys[(i+1)*DIGEST_BITS +: DIGEST_BITS];
            assign no = offs[(i+1)*OW +: OW];
        end
        ssg_cell #(.DIGEST_BITS(DIGEST_BITS), .OFF_W(OW)) u_cell (
            .clk(clk), .rst_n(rst_n), .ctl(ctl),
            .new_key(new_key), .new_off(fill_reg[OW-1:0]), .mask(mask),
            .prev_valid(pv), .prev_gt(pg), .prev_key(pk), .prev_off(po),
            .nxt_valid(nv), .nxt_key(nk), .nxt_off(no),
            .valid(v[i]), .gt(g[i]),
            .key(keys[i*DIGEST_BITS +: DIGEST_BITS]), .off(offs[i*OW +: OW])
        );
    end

    ssg_group #(.DIGEST_BITS(DIGEST_BITS), .SEGMENT_DEPTH(SEGMENT_DEPTH)) u_group (
        .clk(clk), .rst_n(rst_n), .start_seg(closing), .seg_len(fill_reg),
        .emit(drain_reg), .mask(mask), .fin(fin_reg), .keys(keys),
        .head_off(offs[OW-1:0]), .base(base_reg), .fsize(fsize_reg),
        .res(gres), .done(done)
    );

    always_comb
    begin
        fill_next = fill_reg;
        drain_next = drain_reg;
        fin_next = fin_reg;
        base_next = base_reg;
        fsize_next = fsize_reg;
        if (accept)
        begin
            fill_next = fill_reg + 1'b1;
            if (fill_reg == '0)
            begin
                base_next = req.segment_base;
                fsize_next = req.size_of_file;
            end
            if (closing)
            begin
                drain_next = 1'b1;
                fin_next = req.final_segment;
            end
        end
        if (done)
        begin
            drain_next = 1'b0;
            fill_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbytes_reg <= ssg_pkg::DBYTES_RESET;
            fill_reg <= '0;
            drain_reg <= 1'b0;
            fin_reg <= 1'b0;
            base_reg <= '0;
            fsize_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                dbytes_reg <= cfg_wdata;
            end
            fill_reg <= fill_next;
            drain_reg <= drain_next;
            fin_reg <= fin_next;
            base_reg <= base_next;
            fsize_reg <= fsize_next;
        end
    end

    assign res_valid = drain_reg;
    assign res = gres;
endmodule

// ===== sv/ssg_checker.sv =====
// Port-level checker for the grouper, bound to the top level.
// Depends on ssg_pkg and the defines header.
`include "segment_sort_equal_digest_grouper_top_defines.svh"
module ssg_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          busy,
    input logic          res_valid,
    input ssg_pkg::res_t res
);
    `SSG_ASSERT_IMPL(a_valid_busy, clk, rst_n, res_valid, busy)
    `SSG_ASSERT_NEXT(a_last_ends, clk, rst_n, res_valid && res.last_result, !res_valid)
    `SSG_ASSERT_IMPL(a_group_size, clk, rst_n, res_valid && res.in_group, res.group_size >= ssg_pkg::GROUP_MIN)
    `SSG_ASSERT_IMPL(a_single_num, clk, rst_n, res_valid && !res.in_group, res.group_number == '0)
endmodule

bind segment_sort_equal_digest_grouper_top ssg_checker u_ssg_checker (
    .clk(clk), .rst_n(rst_n), .busy(busy),
    .res_valid(res_valid), .res(res)
);

// ===== test/segment_sort_equal_digest_grouper_top_tb.sv =====
// Testbench for the segment sorter and grouper: random and directed segments
// checked against a behavioural sort-and-group predictor in a scoreboard class.
// Depends on ssg_pkg and segment_sort_equal_digest_grouper_top.
module segment_sort_equal_digest_grouper_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam int CYCLE_LIMIT = 400000;

    class group_scoreboard;
        logic [255:0] seg_digest[DEPTH];
        int unsigned  seg_fill;
        logic [31:0]  seg_base;
        logic [47:0]  seg_size;
        logic [31:0]  grp_count;
        logic [5:0]   cmp_bytes;
        ssg_pkg::res_t pending[$];
        int unsigned  errors;

        function new();
            seg_fill = 0;
            seg_base = '0;
            seg_size = '0;
            grp_count = '0;
            cmp_bytes = ssg_pkg::DBYTES_RESET;
            errors = 0;
        endfunction

        function int key_cmp(int a, int b, int n);
            int i;
            logic [7:0] x;
            logic [7:0] y;
            for (i = 0; i < n; i++)
            begin
                x = seg_digest[a][255 - 8 * i -: 8];
                y = seg_digest[b][255 - 8 * i -: 8];
                if (x != y)
                    return (x < y) ? -1 : 1;
            end
            return 0;
        endfunction

        // note an accepted request; predict the segment's results on close
        function void note_request(ssg_pkg::req_t r);
            int n;
            int cl;
            int k;
            int j;
            int t;
            int s;
            int e;
            int order[DEPTH];
            ssg_pkg::res_t o;
            if (seg_fill == 0)
            begin
                seg_base = r.segment_base;
                seg_size = r.size_of_file;
            end
            seg_digest[seg_fill] = {r.digest_word0, r.digest_word1,
                                    r.digest_word2, r.digest_word3};
            seg_fill++;
            n = seg_fill;
            if (!r.last_in_segment && n < DEPTH)
                return;
            cl = (cmp_bytes > 32) ? 32 : cmp_bytes;
            for (k = 0; k < n; k++)
                order[k] = k;
            for (k = 1; k < n; k++)
            begin
                t = order[k];
                j = k;
                while (j > 0 && key_cmp(order[j - 1], t, cl) > 0)
                begin
                    order[j] = order[j - 1];
                    j--;
                end
                order[j] = t;
            end
            s = 0;
            while (s < n)
            begin
                e = s + 1;
                while (e < n && key_cmp(order[e], order[s], cl) == 0)
                    e++;
                for (k = s; k < e; k++)
                begin
                    o.source_offset = 6'(order[k]);
                    o.in_group = (e - s) >= 2;
                    o.group_start = seg_base + 32'(s);
                    o.group_size = 7'(e - s);
                    o.group_file_size = seg_size;
                    o.group_number = o.in_group ? grp_count : '0;
                    o.run_first = (k == s);
                    o.last_result = (k == n - 1);
                    pending.push_back(o);
                end
                if ((e - s) >= 2 && grp_count != 32'hFFFF_FFFF)
                    grp_count++;
                s = e;
            end
            seg_fill = 0;
            if (r.final_segment)
                grp_count = '0;
        endfunction

        function void check_result(ssg_pkg::res_t got);
            ssg_pkg::res_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result expected none actual %h", $realtime, got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                errors++;
                $display("%0t: mismatch expected %h actual %h", $realtime, want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    ssg_pkg::req_t req;
    logic res_valid;
    ssg_pkg::res_t res;
    logic cfg_we;
    logic [ssg_pkg::DBYTES_W-1:0] cfg_wdata;
    int unsigned cycles;
    group_scoreboard board;

    segment_sort_equal_digest_grouper_top u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .res_valid(res_valid), .res(res), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        if (rst_n && res_valid)
            board.check_result(res);
    end

    // drop start for a random gap; a zero gap keeps the next request back to back
    task automatic idle_gap();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            g = 0;
        if (g > 0)
        begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // drive one request and hold it until accepted
    task automatic send_request(ssg_pkg::req_t r);
        start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_request(r);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_cmp_bytes(logic [5:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.cmp_bytes = v;
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    // with a chance of bias percent, digests drawn from a small pool so that equal runs are common
    function automatic ssg_pkg::req_t pool_request(int pool, int bias);
        ssg_pkg::req_t r;
        r.digest_word0 = rnd64();
        r.digest_word1 = rnd64();
        r.digest_word2 = rnd64();
        r.digest_word3 = rnd64();
        if ($urandom_range(0, 99) < bias)
        begin
            r.digest_word0 = {8'($urandom_range(0, pool)), 56'h0};
            r.digest_word1 = '0;
            r.digest_word2 = 64'($urandom_range(0, 1));
            r.digest_word3 = {63'h0, 1'($urandom_range(0, 1))};
        end
        r.segment_base = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFF0 + $urandom_range(0, 15)
                                                      : $urandom();
        r.size_of_file = 48'({$urandom(), $urandom()});
        r.last_in_segment = 1'b0;
        r.final_segment = 1'($urandom_range(0, 1));
        return r;
    endfunction

    task automatic send_segment(int n, int pool, int bias, logic fin);
        ssg_pkg::req_t r;
        int i;
        for (i = 0; i < n; i++)
        begin
            r = pool_request(pool, bias);
            r.last_in_segment = (i == n - 1) || ($urandom_range(0, 40) == 0);
            r.final_segment = fin;
            send_request(r);
            idle_gap();
            if (r.last_in_segment)
                break;
        end
    endtask

    initial
    begin
        ssg_pkg::req_t r;
        int sent;
        int n;
        board = new();
        cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-entry segment, all-ones fields
        r = '1;
        send_request(r);
        // all-zero entries, duplicates form a group
        r = '0;
        send_request(r);
        r.segment_base = 32'hFFFF_FFFF;
        send_request(r);
        r.last_in_segment = 1'b1;
        send_request(r);
        // descending digests, one byte differs late
        r = '1;
        r.last_in_segment = 1'b0;
        send_request(r);
        r.digest_word3 = 64'hFFFF_FFFF_FFFF_FFFE;
        send_request(r);
        r.digest_word0 = 64'h7FFF_FFFF_FFFF_FFFF;
        r.last_in_segment = 1'b1;
        r.final_segment = 1'b0;
        send_request(r);
        // full segment closes without a last mark
        send_segment(DEPTH + 1, 3, 80, 1'b0);
        drain();
        // compare length zero: everything in one run
        write_cmp_bytes(6'd0);
        send_segment(5, 255, 0, 1'b1);
        write_cmp_bytes(6'd63);
        send_segment(6, 2, 90, 1'b0);
        write_cmp_bytes(6'd1);
        send_segment(8, 255, 0, 1'b0);
        write_cmp_bytes(6'd32);

        sent = 0;
        while (sent < 380)
        begin
            if ($urandom_range(0, 15) == 0)
                write_cmp_bytes(6'($urandom_range(0, 63)));
            n = ($urandom_range(0, 15) == 0) ? DEPTH : $urandom_range(1, 12);
            send_segment(n, $urandom_range(0, 5), $urandom_range(0, 100),
                         1'($urandom_range(0, 3) == 0));
            sent += n;
            if ($urandom_range(0, 7) == 0)
                drain();
        end
        drain();
        repeat (140) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
